// ===== rtl/fft_pkg.sv =====
// Shared types, twiddle ROM and helpers for the radix-2 FFT.
`timescale 1ns / 1ps

package fft_pkg;

  localparam int IW = 16;  // input part width
  localparam int DW = 26;  // internal part width, holds unscaled growth
  localparam int OW = 24;  // output part width
  localparam int KW = 7;   // twiddle ROM index width

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic  v;
    cplx_t a;
    cplx_t t;
  } bfly_t;

  typedef struct packed {
    logic signed [IW-1:0] in_re0;
    logic signed [IW-1:0] in_im0;
    logic signed [IW-1:0] in_re1;
    logic signed [IW-1:0] in_im1;
    logic signed [IW-1:0] in_re2;
    logic signed [IW-1:0] in_im2;
    logic signed [IW-1:0] in_re3;
    logic signed [IW-1:0] in_im3;
  } fft_in_t;

  typedef struct packed {
    logic signed [OW-1:0] out_re0;
    logic signed [OW-1:0] out_im0;
    logic signed [OW-1:0] out_re1;
    logic signed [OW-1:0] out_im1;
    logic signed [OW-1:0] out_re2;
    logic signed [OW-1:0] out_im2;
    logic signed [OW-1:0] out_re3;
    logic signed [OW-1:0] out_im3;
    logic                 last_group;
  } fft_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } st_e;

  // round(32768 * sin(pi*k/128)), k = 0..64, top entry saturated
  function automatic logic signed [IW-1:0] qsin(input logic [KW-1:0] k);
    logic signed [IW-1:0] r;
    case (k)
      7'd0:  r = 16'sd0;     7'd1:  r = 16'sd804;   7'd2:  r = 16'sd1608;
      7'd3:  r = 16'sd2411;  7'd4:  r = 16'sd3212;  7'd5:  r = 16'sd4011;
      7'd6:  r = 16'sd4808;  7'd7:  r = 16'sd5602;  7'd8:  r = 16'sd6393;
      7'd9:  r = 16'sd7180;  7'd10: r = 16'sd7962;  7'd11: r = 16'sd8740;
      7'd12: r = 16'sd9512;  7'd13: r = 16'sd10279; 7'd14: r = 16'sd11039;
      7'd15: r = 16'sd11793; 7'd16: r = 16'sd12540; 7'd17: r = 16'sd13279;
      7'd18: r = 16'sd14010; 7'd19: r = 16'sd14733; 7'd20: r = 16'sd15447;
      7'd21: r = 16'sd16151; 7'd22: r = 16'sd16846; 7'd23: r = 16'sd17531;
      7'd24: r = 16'sd18205; 7'd25: r = 16'sd18868; 7'd26: r = 16'sd19520;
      7'd27: r = 16'sd20160; 7'd28: r = 16'sd20788; 7'd29: r = 16'sd21403;
      7'd30: r = 16'sd22006; 7'd31: r = 16'sd22595; 7'd32: r = 16'sd23170;
      7'd33: r = 16'sd23732; 7'd34: r = 16'sd24279; 7'd35: r = 16'sd24812;
      7'd36: r = 16'sd25330; 7'd37: r = 16'sd25833; 7'd38: r = 16'sd26320;
      7'd39: r = 16'sd26791; 7'd40: r = 16'sd27246; 7'd41: r = 16'sd27684;
      7'd42: r = 16'sd28106; 7'd43: r = 16'sd28511; 7'd44: r = 16'sd28899;
      7'd45: r = 16'sd29269; 7'd46: r = 16'sd29622; 7'd47: r = 16'sd29957;
      7'd48: r = 16'sd30274; 7'd49: r = 16'sd30572; 7'd50: r = 16'sd30853;
      7'd51: r = 16'sd31114; 7'd52: r = 16'sd31357; 7'd53: r = 16'sd31581;
      7'd54: r = 16'sd31786; 7'd55: r = 16'sd31972; 7'd56: r = 16'sd32138;
      7'd57: r = 16'sd32286; 7'd58: r = 16'sd32413; 7'd59: r = 16'sd32522;
      7'd60: r = 16'sd32610; 7'd61: r = 16'sd32679; 7'd62: r = 16'sd32729;
      7'd63: r = 16'sd32758; 7'd64: r = 16'sd32767;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [IW-1:0] rom_cos(input logic [KW-1:0] k);
    logic signed [IW-1:0] r;
    if (k <= 7'd64) r = qsin(7'd64 - k);
    else            r = -qsin(k - 7'd64);
    return r;
  endfunction

  function automatic logic signed [IW-1:0] rom_sin(input logic [KW-1:0] k);
    logic signed [IW-1:0] r;
    if (k <= 7'd64) r = qsin(k);
    else            r = qsin(KW'(8'd128 - {1'b0, k}));
    return r;
  endfunction

  function automatic logic signed [OW-1:0] sat_out(input logic signed [DW-1:0] v);
    logic signed [OW-1:0] r;
    if (v[DW-1:OW-1] == '0 || v[DW-1:OW-1] == '1) r = v[OW-1:0];
    else if (v[DW-1])                            r = {1'b1, {(OW-1){1'b0}}};
    else                                         r = {1'b0, {(OW-1){1'b1}}};
    return r;
  endfunction

endpackage

// ===== rtl/fft_mem.sv =====
// Working store: two banks split by address parity, one write and one read port each.
`timescale 1ns / 1ps

module fft_mem
  import fft_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we0_i,
  input  logic [$clog2(DEPTH)-1:0] waddr0_i,
  input  cplx_t                    wdata0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  output cplx_t                    rdata0_o,
  input  logic                     we1_i,
  input  logic [$clog2(DEPTH)-1:0] waddr1_i,
  input  cplx_t                    wdata1_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output cplx_t                    rdata1_o
);

  cplx_t bank0_q [DEPTH];
  cplx_t bank1_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we0_i) begin
      bank0_q[waddr0_i] <= wdata0_i;
    end
    rdata0_o <= bank0_q[raddr0_i];
  end

  always_ff @(posedge clk_i) begin
    if (we1_i) begin
      bank1_q[waddr1_i] <= wdata1_i;
    end
    rdata1_o <= bank1_q[raddr1_i];
  end

endmodule

// ===== rtl/fft_cmul.sv =====
// Twiddle multiplier: T = W^k * B, rounded Q1.15, two register stages.
`timescale 1ns / 1ps

module fft_cmul
  import fft_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  cplx_t         b_i,
  input  logic [KW-1:0] k_i,
  output logic          valid_o,
  output cplx_t         t_o
);

  localparam int MW = DW + IW;

  logic signed [IW-1:0] cos_w, sin_w;
  logic signed [MW-1:0] cr_q, si_q, ci_q, sr_q;
  logic                 v1_q, kz_q;
  cplx_t                b1_q;
  logic signed [MW:0]   tre_w, tim_w;

  assign cos_w = rom_cos(k_i);
  assign sin_w = rom_sin(k_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cr_q <= cos_w * b_i.re;
    si_q <= sin_w * b_i.im;
    ci_q <= cos_w * b_i.im;
    sr_q <= sin_w * b_i.re;
    kz_q <= (k_i == '0);
    b1_q <= b_i;
  end

  // rounding: floor((v + 2^14) / 2^15)
  assign tre_w = (MW+1)'(cr_q) + (MW+1)'(si_q) + (MW+1)'(16384);
  assign tim_w = (MW+1)'(ci_q) - (MW+1)'(sr_q) + (MW+1)'(16384);

  always_ff @(posedge clk_i) begin
    if (kz_q) begin
      t_o <= b1_q;
    end else begin
      t_o.re <= tre_w[DW+14:15];
      t_o.im <= tim_w[DW+14:15];
    end
  end

endmodule

// ===== rtl/fft_lane.sv =====
// Butterfly output lane: registered A + T or A - T.
`timescale 1ns / 1ps

module fft_lane
  import fft_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  sub_i,
  input  bfly_t in_i,
  output logic  valid_o,
  output cplx_t y_o
);

  logic signed [DW:0] re_w, im_w;

  always_comb begin
    if (sub_i) begin
      re_w = (DW+1)'(in_i.a.re) - (DW+1)'(in_i.t.re);
      im_w = (DW+1)'(in_i.a.im) - (DW+1)'(in_i.t.im);
    end else begin
      re_w = (DW+1)'(in_i.a.re) + (DW+1)'(in_i.t.re);
      im_w = (DW+1)'(in_i.a.im) + (DW+1)'(in_i.t.im);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= in_i.v;
    end
  end

  always_ff @(posedge clk_i) begin
    y_o.re <= re_w[DW-1:0];
    y_o.im <= im_w[DW-1:0];
  end

endmodule

// ===== rtl/radix2_fft.sv =====
// Top level: load sequencer, butterfly scheduler, two lanes and result unpacking.
//
//  channel  handshake        payload    beat
//  input    start & !busy    item_i     four complex Q1.15 samples
//  result   done_o strobe    result_o   four bins, natural order, last_group on the final one
//
// A group loads in ST_IDLE on acceptance and then in ST_LOAD (two samples per cycle, one per bank).
// After the last group, log2(POINTS) stages of POINTS/2 butterflies run at one
// butterfly per cycle, each stage followed by a drain of the pipeline in ST_DRAIN.
// Results then come out in ST_OUT, each group of four from two bank reads.
// busy is high on each group's second load cycle and from the last group until its final beat.
// Reset drops a partly loaded frame; the receiver cannot stall results.
`timescale 1ns / 1ps

module radix2_fft
  import fft_pkg::*;
#(
  parameter int POINTS = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  fft_in_t  item_i,
  output logic     done_o,
  output fft_out_t result_o
);

  localparam int AW = $clog2(POINTS);
  localparam int BW = AW - 1;
  localparam int GW = AW - 2;
  localparam int SW = $clog2(AW);
  localparam logic [2:0] DRAIN_LAST = 3'd5;

  function automatic logic [AW-1:0] brev(input logic [AW-1:0] x);
    logic [AW-1:0] r;
    for (int i = 0; i < AW; i++) r[i] = x[AW-1-i];
    return r;
  endfunction

  st_e           st_q, st_d;
  logic [GW-1:0] grp_q, grp_d;
  logic [SW-1:0] stg_q, stg_d;
  logic [BW-1:0] bf_q, bf_d;
  logic [2:0]    drn_q, drn_d;
  logic [BW-1:0] oc_q, oc_d;
  logic          oend_q, oend_d;
  fft_in_t       item_q;
  logic          acc;

  assign acc  = start & (st_q == ST_IDLE);
  assign busy = (st_q != ST_IDLE);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      grp_q  <= '0;
      stg_q  <= '0;
      bf_q   <= '0;
      drn_q  <= '0;
      oc_q   <= '0;
      oend_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      grp_q  <= grp_d;
      stg_q  <= stg_d;
      bf_q   <= bf_d;
      drn_q  <= drn_d;
      oc_q   <= oc_d;
      oend_q <= oend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) item_q <= item_i;
  end

  always_comb begin
    st_d   = st_q;
    grp_d  = grp_q;
    stg_d  = stg_q;
    bf_d   = bf_q;
    drn_d  = drn_q;
    oc_d   = oc_q;
    oend_d = oend_q;
    unique case (st_q)
      ST_IDLE: begin
        if (acc) st_d = ST_LOAD;
      end
      ST_LOAD: begin
        grp_d = grp_q + 1'b1;
        if (grp_q == '1) begin
          st_d  = ST_RUN;
          stg_d = '0;
          bf_d  = '0;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_RUN: begin
        bf_d = bf_q + 1'b1;
        if (bf_q == '1) begin
          st_d  = ST_DRAIN;
          drn_d = '0;
        end
      end
      ST_DRAIN: begin
        drn_d = drn_q + 1'b1;
        if (drn_q == DRAIN_LAST) begin
          if (stg_q == SW'(AW - 1)) begin
            st_d   = ST_OUT;
            oc_d   = '0;
            oend_d = 1'b0;
          end else begin
            stg_d = stg_q + 1'b1;
            st_d  = ST_RUN;
          end
        end
      end
      ST_OUT: begin
        if (!oend_q) begin
          oc_d = oc_q + 1'b1;
          if (oc_q == '1) oend_d = 1'b1;
        end
        if (done_o && result_o.last_group) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // ---------------- butterfly addressing ----------------
  logic [AW-1:0] lowmask, nx, a_c, b_c;
  logic [15:0]   j16;
  logic [2:0]    kshift;
  logic [KW-1:0] k_c;

  always_comb begin
    lowmask = (AW'(1) << stg_q) - AW'(1);
    nx      = {1'b0, bf_q};
    a_c     = ((nx & ~lowmask) << 1) | (nx & lowmask);
    b_c     = a_c | (AW'(1) << stg_q);
    j16     = 16'(nx & lowmask);
    kshift  = 3'd7 - 3'(stg_q);
    k_c     = KW'(j16 << kshift);
  end

  // ---------------- memory ports ----------------
  logic          we0, we1;
  logic [BW-1:0] wa0, wa1, ra0, ra1;
  cplx_t         wd0, wd1, rd0, rd1;

  // load side
  logic          lwe, lhi, lpx;
  logic [AW-1:0] lax, lay;
  cplx_t         lsx, lsy;
  fft_in_t       lsrc;

  // lane side
  logic          l0_v, l1_v;
  cplx_t         l0_y, l1_y;
  logic [AW-1:0] a4_q, b4_q;

  always_comb begin
    lwe  = acc | (st_q == ST_LOAD);
    lhi  = (st_q == ST_LOAD);
    lsrc = lhi ? item_q : item_i;
    lax  = brev({grp_q, lhi, 1'b0});
    lay  = brev({grp_q, lhi, 1'b1});
    lpx  = ^lax;
    if (lhi) begin
      lsx.re = DW'(lsrc.in_re2); lsx.im = DW'(lsrc.in_im2);
      lsy.re = DW'(lsrc.in_re3); lsy.im = DW'(lsrc.in_im3);
    end else begin
      lsx.re = DW'(lsrc.in_re0); lsx.im = DW'(lsrc.in_im0);
      lsy.re = DW'(lsrc.in_re1); lsy.im = DW'(lsrc.in_im1);
    end

    if (lwe) begin
      we0 = 1'b1;
      we1 = 1'b1;
      wa0 = lpx ? lay[AW-1:1] : lax[AW-1:1];
      wa1 = lpx ? lax[AW-1:1] : lay[AW-1:1];
      wd0 = lpx ? lsy : lsx;
      wd1 = lpx ? lsx : lsy;
    end else begin
      // merge: sum goes to the lower (A) element's bank, difference to the other
      we0 = l0_v;
      we1 = l1_v;
      wa0 = (^a4_q) ? b4_q[AW-1:1] : a4_q[AW-1:1];
      wa1 = (^a4_q) ? a4_q[AW-1:1] : b4_q[AW-1:1];
      wd0 = (^a4_q) ? l1_y : l0_y;
      wd1 = (^a4_q) ? l0_y : l1_y;
    end

    if (st_q == ST_OUT) begin
      ra0 = oc_q;
      ra1 = oc_q;
    end else begin
      ra0 = (^a_c) ? b_c[AW-1:1] : a_c[AW-1:1];
      ra1 = (^a_c) ? a_c[AW-1:1] : b_c[AW-1:1];
    end
  end

  fft_mem #(
    .DEPTH (POINTS / 2)
  ) u_mem (
    .clk_i    (clk_i),
    .we0_i    (we0),
    .waddr0_i (wa0),
    .wdata0_i (wd0),
    .raddr0_i (ra0),
    .rdata0_o (rd0),
    .we1_i    (we1),
    .waddr1_i (wa1),
    .wdata1_i (wd1),
    .raddr1_i (ra1),
    .rdata1_o (rd1)
  );

  // ---------------- butterfly pipeline ----------------
  logic          v1_q;
  logic [AW-1:0] a1_q, b1_q, a2_q, b2_q, a3_q, b3_q;
  logic [KW-1:0] k1_q;
  cplx_t         a_w, b_w, ad2_q, ad3_q, t_w;
  logic          tv;
  bfly_t         lin0, lin1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= (st_q == ST_RUN);
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q  <= a_c;
    b1_q  <= b_c;
    k1_q  <= k_c;
    a2_q  <= a1_q;
    b2_q  <= b1_q;
    a3_q  <= a2_q;
    b3_q  <= b2_q;
    a4_q  <= a3_q;
    b4_q  <= b3_q;
    ad2_q <= a_w;
    ad3_q <= ad2_q;
  end

  assign a_w = (^a1_q) ? rd1 : rd0;
  assign b_w = (^a1_q) ? rd0 : rd1;

  fft_cmul u_cmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .b_i     (b_w),
    .k_i     (k1_q),
    .valid_o (tv),
    .t_o     (t_w)
  );

  assign lin0 = '{v: tv, a: ad3_q, t: t_w};
  assign lin1 = '{v: tv, a: ad3_q, t: t_w};

  fft_lane u_lane_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sub_i   (1'b0),
    .in_i    (lin0),
    .valid_o (l0_v),
    .y_o     (l0_y)
  );

  fft_lane u_lane_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sub_i   (1'b1),
    .in_i    (lin1),
    .valid_o (l1_v),
    .y_o     (l1_y)
  );

  // ---------------- result unpacking ----------------
  logic     ov1_q, oph1_q, opar1_q, olast1_q;
  cplx_t    x0, x1, h0_q, h1_q;
  logic     done_d;
  fft_out_t res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov1_q  <= 1'b0;
      done_o <= 1'b0;
    end else begin
      ov1_q  <= (st_q == ST_OUT) & ~oend_q;
      done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oph1_q   <= oc_q[0];
    opar1_q  <= ^oc_q;
    olast1_q <= &oc_q[BW-1:1];
    if (ov1_q && !oph1_q) begin
      h0_q <= x0;
      h1_q <= x1;
    end
    if (done_d) result_o <= res_d;
  end

  always_comb begin
    x0 = opar1_q ? rd1 : rd0;
    x1 = opar1_q ? rd0 : rd1;
    done_d = ov1_q & oph1_q;
    res_d.out_re0    = sat_out(h0_q.re);
    res_d.out_im0    = sat_out(h0_q.im);
    res_d.out_re1    = sat_out(h1_q.re);
    res_d.out_im1    = sat_out(h1_q.im);
    res_d.out_re2    = sat_out(x0.re);
    res_d.out_im2    = sat_out(x0.im);
    res_d.out_re3    = sat_out(x1.re);
    res_d.out_im3    = sat_out(x1.im);
    res_d.last_group = olast1_q;
  end

  // ---------------- assertions ----------------
  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result shown while idle");

  a_load_two : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("group load not held for second cycle");

  a_lanes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    l0_v == l1_v) else $error("butterfly lanes out of step");

  a_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.last_group) |=> !done_o) else $error("beat after last group");

  a_no_mix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    l0_v |-> !(st_q == ST_IDLE || st_q == ST_LOAD)) else $error("lane write during load");

endmodule
